/* sv/apcwb_pkg.sv */
`default_nettype none
package apcwb_pkg;

    localparam int FRAME_LEN  = 25;
    localparam int CRC_FIRST  = 11;
    localparam int CRC_LAST   = 22;
    localparam int CRC_HI_POS = 23;
    localparam int LAST_POS   = 24;
    localparam int POS_W      = $clog2(FRAME_LEN + 1);
    localparam int RAM_DEPTH  = 32;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] POLY_RESET  = 16'h1021;
    localparam logic [6:0]  WHITEN_SEED = 7'd83;
    localparam int          WHITEN_SKIP = 104;
    localparam int          BYTE_BITS   = 8;

    localparam logic [1:0] CMD_SETUP = 2'd0;
    localparam logic [1:0] CMD_ON    = 2'd1;
    localparam logic [1:0] CMD_OFF   = 2'd2;
    localparam logic [1:0] CMD_LIGHT = 2'd3;

    localparam logic [7:0] CODE_SETUP = 8'h28;
    localparam logic [7:0] CODE_ON    = 8'h10;
    localparam logic [7:0] CODE_OFF   = 8'h11;
    localparam logic [7:0] CODE_LIGHT = 8'h21;

    localparam int         CFG_IDX_W       = 8;
    localparam logic [7:0] CFG_PREFIX_HEAD = 8'd0;
    localparam logic [7:0] CFG_PREFIX_TAIL = 8'd1;
    localparam logic [7:0] CFG_DEVICE_ID   = 8'd2;
    localparam logic [7:0] CFG_CRC_POLY    = 8'd3;

    typedef struct packed {
        logic init;
        logic load;
        logic last;
    } t_wht_ctrl;

    function automatic logic [6:0] lfsr_step(input logic [6:0] l);
        logic top;
        top = l[6];
        return {l[5:0], top} ^ {2'b00, top, 4'b0000};
    endfunction

    function automatic logic [6:0] lfsr_skip(input logic [6:0] l, input int n);
        logic [6:0] v;
        v = l;
        for (int i = 0; i < n; i++) begin
            v = lfsr_step(v);
        end
        return v;
    endfunction

    localparam logic [6:0] WHITEN_START = lfsr_skip(WHITEN_SEED, WHITEN_SKIP);

    function automatic logic [7:0] reverse_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = b[7 - k];
        end
        return r;
    endfunction

    function automatic logic [7:0] whiten_byte(input logic [7:0] b, input logic [6:0] l);
        logic [7:0] r;
        logic [6:0] v;
        v = l;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[6] ^ b[k];
            v = lfsr_step(v);
        end
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* sv/apcwb_frame_ram.sv */
`default_nettype none
module apcwb_frame_ram
    import apcwb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]        o_rd_data
);

    logic [7:0] r_mem [RAM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* sv/apcwb_crc_unit.sv */
`default_nettype none
module apcwb_crc_unit
    import apcwb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_clear,
    input  wire logic        i_feed,
    input  wire logic [7:0]  i_byte,
    input  wire logic [15:0] i_poly,
    output logic      [15:0] o_crc
);

    logic [15:0] r_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (i_clear) begin
            r_crc <= CRC_INIT;
        end else if (i_feed) begin
            r_crc <= crc_byte(r_crc, i_byte, i_poly);
        end
    end

    assign o_crc = r_crc;

endmodule
`default_nettype wire

/* sv/apcwb_whiten_out.sv */
`default_nettype none
module apcwb_whiten_out
    import apcwb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_wht_ctrl  i_ctrl,
    input  wire logic [7:0] i_rd_data,
    input  wire logic       i_tready,
    output logic            o_tvalid,
    output logic      [7:0] o_tdata,
    output logic            o_tlast
);

    logic       r_valid;
    logic [6:0] r_lfsr;
    logic [7:0] r_data;
    logic       r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lfsr  <= WHITEN_START;
        end else begin
            if (i_ctrl.load) begin
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
            if (i_ctrl.init) begin
                r_lfsr <= WHITEN_START;
            end else if (i_ctrl.load) begin
                r_lfsr <= lfsr_skip(r_lfsr, BYTE_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_data <= whiten_byte(reverse_byte(i_rd_data), r_lfsr);
            r_last <= i_ctrl.last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule
`default_nettype wire

/* sv/adv_packet_crc_whitening_builder.sv */
// an accepted request first builds the whole frame into the frame ram; each byte is then read
// out of its one read port and registered in the whitening output stage, one read in flight at a time,
// and a new request is taken only after the last frame byte has been read out
// reset: synchronous active low, clears control, crc and whitening state, config to defaults
// the frame ram has no reset; every entry is written before it is read
`default_nettype none
module adv_packet_crc_whitening_builder
    import apcwb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [1:0] command, [9:2] channel_one_level, [17:10] channel_two_level, [25:18] nonce
    input  wire logic [31:0]          s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [7:0] frame_byte
    output logic      [7:0]           m_axis_tdata,
    output logic                      m_axis_tlast,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_EMIT
    } t_state;

    t_state           r_state;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_rd_idx;
    logic             r_pend;
    logic             r_pend_last;

    logic [23:0] r_prefix_head;
    logic [63:0] r_prefix_tail;
    logic [15:0] r_device_id;
    logic [15:0] r_crc_poly;

    logic [1:0] r_cmd;
    logic [7:0] r_lv1;
    logic [7:0] r_lv2;
    logic [7:0] r_nonce;

    logic        in_acc;
    logic        wr_en;
    logic        rd_en;
    logic        crc_feed;
    logic [7:0]  wr_byte;
    logic [7:0]  rd_data;
    logic [15:0] crc_value;
    logic [7:0]  code;
    logic [7:0]  arg1;
    logic [7:0]  arg2;
    t_wht_ctrl   wht_ctrl;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign wr_en         = (r_state == ST_BUILD);
    assign crc_feed      = wr_en && (r_pos >= POS_W'(CRC_FIRST)) && (r_pos <= POS_W'(CRC_LAST));
    assign rd_en         = (r_state == ST_EMIT) && (r_rd_idx != POS_W'(FRAME_LEN)) && !r_pend
                           && (!m_axis_tvalid || m_axis_tready);

    always_comb begin
        case (r_cmd)
            CMD_SETUP: begin
                code = CODE_SETUP;
                arg1 = r_device_id[15:8];
                arg2 = r_device_id[7:0];
            end
            CMD_ON: begin
                code = CODE_ON;
                arg1 = 8'h00;
                arg2 = 8'h00;
            end
            CMD_OFF: begin
                code = CODE_OFF;
                arg1 = 8'h00;
                arg2 = 8'h00;
            end
            CMD_LIGHT: begin
                code = CODE_LIGHT;
                arg1 = r_lv1;
                arg2 = r_lv2;
            end
            default: begin
                code = CODE_LIGHT;
                arg1 = r_lv1;
                arg2 = r_lv2;
            end
        endcase
    end

    // frame byte at the build position
    always_comb begin
        case (r_pos)
            5'd0:    wr_byte = r_prefix_head[23:16];
            5'd1:    wr_byte = r_prefix_head[15:8];
            5'd2:    wr_byte = r_prefix_head[7:0];
            5'd3:    wr_byte = r_prefix_tail[63:56];
            5'd4:    wr_byte = r_prefix_tail[55:48];
            5'd5:    wr_byte = r_prefix_tail[47:40];
            5'd6:    wr_byte = r_prefix_tail[39:32];
            5'd7:    wr_byte = r_prefix_tail[31:24];
            5'd8:    wr_byte = r_prefix_tail[23:16];
            5'd9:    wr_byte = r_prefix_tail[15:8];
            5'd10:   wr_byte = r_prefix_tail[7:0];
            5'd11:   wr_byte = code;
            5'd12:   wr_byte = r_device_id[15:8];
            5'd13:   wr_byte = r_device_id[7:0];
            5'd14:   wr_byte = arg1;
            5'd15:   wr_byte = arg2;
            5'd17:   wr_byte = r_nonce;
            5'd23:   wr_byte = crc_value[15:8];
            5'd24:   wr_byte = crc_value[7:0];
            default: wr_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pos         <= '0;
            r_rd_idx      <= '0;
            r_pend        <= 1'b0;
            r_pend_last   <= 1'b0;
            r_prefix_head <= '0;
            r_prefix_tail <= '0;
            r_device_id   <= '0;
            r_crc_poly    <= POLY_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PREFIX_HEAD: r_prefix_head <= i_cfg_data[23:0];
                    CFG_PREFIX_TAIL: r_prefix_tail <= i_cfg_data;
                    CFG_DEVICE_ID:   r_device_id   <= i_cfg_data[15:0];
                    CFG_CRC_POLY:    r_crc_poly    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            r_pend      <= rd_en;
            r_pend_last <= rd_en && (r_rd_idx == POS_W'(LAST_POS));
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_pos   <= '0;
                        r_state <= ST_BUILD;
                    end
                end
                ST_BUILD: begin
                    r_pos <= POS_W'(r_pos + 1'b1);
                    if (r_pos == POS_W'(LAST_POS)) begin
                        r_rd_idx <= '0;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (rd_en) begin
                        r_rd_idx <= POS_W'(r_rd_idx + 1'b1);
                    end
                    if ((r_rd_idx == POS_W'(FRAME_LEN)) && !r_pend) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= s_axis_tdata[1:0];
            r_lv1   <= s_axis_tdata[9:2];
            r_lv2   <= s_axis_tdata[17:10];
            r_nonce <= s_axis_tdata[25:18];
        end
    end

    assign wht_ctrl.init = in_acc;
    assign wht_ctrl.load = r_pend;
    assign wht_ctrl.last = r_pend_last;

    apcwb_frame_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(r_pos)),
        .i_wr_data (wr_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (ADDR_W'(r_rd_idx)),
        .o_rd_data (rd_data)
    );

    apcwb_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (in_acc),
        .i_feed  (crc_feed),
        .i_byte  (wr_byte),
        .i_poly  (r_crc_poly),
        .o_crc   (crc_value)
    );

    apcwb_whiten_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (wht_ctrl),
        .i_rd_data (rd_data),
        .i_tready  (m_axis_tready),
        .o_tvalid  (m_axis_tvalid),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // read data lands only in an empty output register
    a_pend_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !m_axis_tvalid)
        else $error("ram read data arrived while output register busy");

    a_pend_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> m_axis_tvalid)
        else $error("ram read data was not loaded into output register");

    a_ram_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !rd_en)
        else $error("frame ram written and read in the same cycle");

    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (crc_value == CRC_INIT))
        else $error("crc not restarted on new request");
`endif

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import apcwb_pkg::*;

    localparam int          CYCLE_LIMIT       = 500000;
    localparam int          RANDOM_PER_PHASE  = 80;
    localparam int          PHASE_COUNT       = 6;
    localparam int          HOLD_OFF_CYCLES   = 600;
    localparam int          DRAIN_CYCLES      = 60;
    localparam logic [7:0]  CFG_IDX_UNUSED_LO = CFG_CRC_POLY + 8'd1;
    localparam logic [7:0]  CFG_IDX_UNUSED_HI = 8'hFF;

    // packed msb first, so the struct is the tdata word
    typedef struct packed {
        logic [5:0] pad;
        logic [7:0] nonce;
        logic [7:0] level_two;
        logic [7:0] level_one;
        logic [1:0] cmd;
    } t_lamp_req;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_beat;

    localparam t_lamp_req DIRECTED_REQS [12] = '{
        '{6'h00, 8'h00, 8'h00, 8'h00, CMD_SETUP},
        '{6'h00, 8'h00, 8'h00, 8'h00, CMD_ON},
        '{6'h00, 8'h00, 8'h00, 8'h00, CMD_OFF},
        '{6'h00, 8'h00, 8'h00, 8'h00, CMD_LIGHT},
        '{6'h3F, 8'hFF, 8'hFF, 8'hFF, CMD_LIGHT},
        '{6'h15, 8'h55, 8'h00, 8'hFF, CMD_LIGHT},
        '{6'h2A, 8'hAA, 8'hFF, 8'h00, CMD_LIGHT},
        '{6'h3F, 8'hFF, 8'hFF, 8'hFF, CMD_SETUP},
        '{6'h3F, 8'hFF, 8'hFF, 8'hFF, CMD_ON},
        '{6'h20, 8'h80, 8'h01, 8'h80, CMD_OFF},
        '{6'h01, 8'h7F, 8'h80, 8'h01, CMD_LIGHT},
        '{6'h0C, 8'h80, 8'h55, 8'hAA, CMD_LIGHT}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    logic [23:0] cfg_head;
    logic [63:0] cfg_tail;
    logic [15:0] cfg_id;
    logic [15:0] cfg_poly;

    t_frame_beat frame_bytes_due[$];
    int          mismatch_count;
    int          cycle_count;
    bit          idle_on;
    int          hold_off_len;

    adv_packet_crc_whitening_builder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic logic [6:0] whiten_next(input logic [6:0] w);
        return {w[5:0], w[6]} ^ (w[6] ? 7'h10 : 7'h00);
    endfunction

    function automatic void predict_frame(input t_lamp_req r);
        logic [7:0]  fb [FRAME_LEN];
        logic [7:0]  code;
        logic [7:0]  arg1;
        logic [7:0]  arg2;
        logic [7:0]  wb;
        logic [15:0] acc;
        logic [6:0]  wreg;
        t_frame_beat beat;
        case (r.cmd)
            CMD_SETUP: begin
                code = CODE_SETUP;
                arg1 = cfg_id[15:8];
                arg2 = cfg_id[7:0];
            end
            CMD_ON: begin
                code = CODE_ON;
                arg1 = 8'h00;
                arg2 = 8'h00;
            end
            CMD_OFF: begin
                code = CODE_OFF;
                arg1 = 8'h00;
                arg2 = 8'h00;
            end
            default: begin
                code = CODE_LIGHT;
                arg1 = r.level_one;
                arg2 = r.level_two;
            end
        endcase
        for (int i = 0; i < FRAME_LEN; i++) fb[i] = 8'h00;
        fb[0] = cfg_head[23:16];
        fb[1] = cfg_head[15:8];
        fb[2] = cfg_head[7:0];
        for (int i = 0; i < 8; i++) fb[3 + i] = cfg_tail[63 - 8 * i -: 8];
        fb[11] = code;
        fb[12] = cfg_id[15:8];
        fb[13] = cfg_id[7:0];
        fb[14] = arg1;
        fb[15] = arg2;
        fb[17] = r.nonce;
        acc = CRC_INIT;
        for (int i = CRC_FIRST; i <= CRC_LAST; i++) begin
            acc = acc ^ {fb[i], 8'h00};
            for (int k = 0; k < 8; k++) begin
                acc = {acc[14:0], 1'b0} ^ (acc[15] ? cfg_poly : 16'h0000);
            end
        end
        fb[CRC_HI_POS] = acc[15:8];
        fb[LAST_POS]   = acc[7:0];
        wreg = WHITEN_SEED;
        for (int i = 0; i < WHITEN_SKIP; i++) wreg = whiten_next(wreg);
        // bit reversal folded into the lsb-first whitening
        for (int i = 0; i < FRAME_LEN; i++) begin
            for (int k = 0; k < 8; k++) begin
                wb[k] = wreg[6] ^ fb[i][7 - k];
                wreg  = whiten_next(wreg);
            end
            beat.data = wb;
            beat.last = (i == LAST_POS);
            frame_bytes_due.push_back(beat);
        end
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_lamp_req rand_req();
        t_lamp_req r;
        r.cmd       = 2'($urandom_range(3));
        r.level_one = rand_level();
        r.level_two = rand_level();
        r.nonce     = rand_level();
        r.pad       = 6'($urandom);
        return r;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // leaves valid high so back-to-back writes need one assignment per step
    task automatic cfg_write(input logic [7:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PREFIX_HEAD: cfg_head = val[23:0];
            CFG_PREFIX_TAIL: cfg_tail = val;
            CFG_DEVICE_ID:   cfg_id   = val[15:0];
            CFG_CRC_POLY:    cfg_poly = val[15:0];
            default: ;
        endcase
    endtask

    task automatic send_req(input t_lamp_req r);
        if (idle_on && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frame(r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // output side: random stalls plus an occasional long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len > 0) begin
                stall_left   = hold_off_len;
                hold_off_len = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on) begin
                m_axis_tready <= ($urandom_range(99) >= 24);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_bytes_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected frame byte, expected none, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = frame_bytes_due.pop_front();
                if (m_axis_tdata !== want.data) begin
                    mismatch_count++;
                    $display("%0t: frame_byte mismatch, expected %h actual %h",
                             $time, want.data, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last) begin
                    mismatch_count++;
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    initial begin
        mismatch_count = 0;
        idle_on        = 1'b1;
        hold_off_len   = 0;
        cfg_head       = '0;
        cfg_tail       = '0;
        cfg_id         = '0;
        cfg_poly       = POLY_RESET;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults after reset
        foreach (DIRECTED_REQS[i]) send_req(DIRECTED_REQS[i]);
        drain();

        for (int p = 1; p <= PHASE_COUNT; p++) begin
            case (p)
                1: begin
                    // all ones on every register, out-of-width bits too where the register is narrower
                    cfg_write(CFG_PREFIX_HEAD, '1);
                    cfg_write(CFG_PREFIX_TAIL, '1);
                    cfg_write(CFG_DEVICE_ID, '1);
                    cfg_write(CFG_CRC_POLY, '1);
                    cfg_write(CFG_IDX_UNUSED_HI, '0);
                end
                2: begin
                    cfg_write(CFG_PREFIX_HEAD, '0);
                    cfg_write(CFG_PREFIX_TAIL, '0);
                    cfg_write(CFG_DEVICE_ID, '0);
                    cfg_write(CFG_CRC_POLY, '0);
                    cfg_write(CFG_IDX_UNUSED_LO, '1);
                end
                default: begin
                    cfg_write(CFG_PREFIX_HEAD, rand_word());
                    cfg_write(CFG_PREFIX_TAIL, rand_word());
                    cfg_write(CFG_DEVICE_ID, rand_word());
                    if (p == 3)
                        cfg_write(CFG_CRC_POLY, {48'(rand_word()), POLY_RESET});
                    else
                        cfg_write(CFG_CRC_POLY, rand_word());
                    cfg_write(8'($urandom_range(CFG_IDX_UNUSED_LO, CFG_IDX_UNUSED_HI)),
                              rand_word());
                end
            endcase
            i_cfg_valid <= 1'b0;
            idle_on = (p != 3);
            if (p == 4) hold_off_len = HOLD_OFF_CYCLES;
            repeat (RANDOM_PER_PHASE) send_req(rand_req());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
